/* rtl/skli_pkg.sv */
`default_nettype none

package skli_pkg;

  // Converter resolution; full scale (2^SampleBits - 1) equals 5 V
  localparam int SampleBits = 10;
  localparam int SampleFs   = (1 << SampleBits) - 1;

  // Q3.16 voltage, Q1.32 variance and gain
  localparam int VoltW    = 19;
  localparam int FracBits = 32;
  localparam int NoiseW   = 32;
  localparam int VarW     = FracBits + 1;
  localparam int PcW      = FracBits + 2;
  localparam int DenW     = FracBits + 3;
  localparam int ProdW    = 2 * FracBits;

  // Gain divide: one quotient bit per step
  localparam int QuoW = FracBits;
  localparam int CntW = $clog2(QuoW);

  // Scaling: sample*5*2^16/FS = ScaleQ*sample + (ScaleR*sample + FS/2)/FS
  localparam int VoltScale = 5 * 65536;
  localparam int ScaleQ    = VoltScale / SampleFs;
  localparam int ScaleR    = VoltScale % SampleFs;
  localparam int ScaleW    = 2 * SampleBits + 1;

  localparam logic [VoltW-1:0] VoltFull = VoltW'(VoltScale);

  localparam int PctW     = 7;
  localparam int ThrW     = 7;
  localparam int BandW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [PctW-1:0] PctMax = PctW'(100);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MEAS_NOISE,
    REG_PROC_NOISE,
    REG_HIGH_THR,
    REG_MID_THR
  } cfg_reg_e;

  typedef enum logic [BandW-1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } band_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GSET,
    ST_GDIV,
    ST_MUL_VAR,
    ST_MUL_STEP,
    ST_UPDATE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* rtl/scalar_kalman_level_indicator.sv */
// Scalar Kalman level indicator.
// Input channel (in_valid_i/in_ready_o) takes one raw converter word per item;
// output channel (out_valid_o/out_ready_i) returns one word per item with the
// filtered voltage (Q3.16), its 0..100 percent and the low/mid/high band.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
// 0 measurement noise, 1 process noise, 2 high threshold, 3 mid threshold.
// One shift/compare/subtract unit works out the gain a bit per cycle, and one
// 32x32 multiplier is shared by the variance and estimate updates. Scaling to
// volts is a constant multiple plus a shift-add fold for the divide by 2^n-1.
// From input accept to out_valid_o the block steps through scale and set up,
// the gain divide steps, two multiplies, update and emit; with zero measurement
// noise the gain divide is skipped. in_ready_o is high only while idle, so a
// new item is taken only after the last one has left the emit step.
// The result sits in an output register; if the receiver stalls, the block
// still takes and works the next item, then holds in its last step with
// in_ready_o low until the output register frees.
// Reset: variance 1.0, estimate 0 V, registers to their defaults, output
// channel empty. Reset is asynchronous, active low.
`default_nettype none

module scalar_kalman_level_indicator
  import skli_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_wdata_i,
  // sample input
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [SampleBits-1:0] adc_sample_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [VoltW-1:0]           volt_estimate_o,
  output logic [PctW-1:0]            percent_o,
  output logic [BandW-1:0]           band_o
);

  // configuration registers
  logic [NoiseW-1:0] meas_noise_q, proc_noise_q;
  logic [ThrW-1:0]   high_thr_q, mid_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_noise_q <= NoiseW'(48183);
      proc_noise_q <= NoiseW'(43);
      high_thr_q   <= ThrW'(70);
      mid_thr_q    <= ThrW'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MEAS_NOISE: meas_noise_q <= cfg_wdata_i[NoiseW-1:0];
        REG_PROC_NOISE: proc_noise_q <= cfg_wdata_i[NoiseW-1:0];
        REG_HIGH_THR:   high_thr_q   <= cfg_wdata_i[ThrW-1:0];
        REG_MID_THR:    mid_thr_q    <= cfg_wdata_i[ThrW-1:0];
      endcase
    end
  end

  // sequencer and datapath registers
  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [PcW-1:0]    pc_q, pc_d;
  logic [VarW-1:0]   gain_q, gain_d;
  logic [VoltW-1:0]  vbase_q, vbase_d;
  logic [ScaleW-1:0] vrem_q, vrem_d;
  logic [VoltW-1:0]  v_q, v_d;
  logic [VarW-1:0]   var_q, var_d;
  logic [VoltW-1:0]  est_q, est_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic              out_valid_q, out_valid_d;
  logic [VoltW-1:0]  out_volt_q, out_volt_d;
  logic [PctW-1:0]   out_pct_q, out_pct_d;
  logic [BandW-1:0]  out_band_q, out_band_d;

  // gain divide step: shift in one bit, compare, subtract
  logic [DenW:0]     rem_sh, rem_sub;
  logic              div_ge;
  logic [DenW-1:0]   rem_nx;
  logic [QuoW-1:0]   quo_nx;

  assign rem_sh  = {rem_q, quo_q[QuoW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign div_ge  = rem_sh >= {1'b0, den_q};
  assign rem_nx  = div_ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
  assign quo_nx  = {quo_q[QuoW-2:0], div_ge};

  // scaling: floor(y / (2^n - 1)) = (y + (y >> n) + 1) >> n for these y
  logic [ScaleW-1:0] vfix;
  logic [VoltW-1:0]  v_scaled;
  assign vfix     = vrem_q + (vrem_q >> SampleBits) + ScaleW'(1);
  assign v_scaled = vbase_q + VoltW'(vfix[ScaleW-1:SampleBits]);

  // shared multiplier
  logic [FracBits-1:0] mul_a, mul_b;
  logic [ProdW-1:0]    mul_p;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // 1 - gain, and the measurement-to-estimate distance
  logic [VarW-1:0]  one_minus;
  logic             v_ge;
  logic [VoltW-1:0] diff;
  assign one_minus = {1'b1, {FracBits{1'b0}}} - gain_q;
  assign v_ge      = v_q >= est_q;
  assign diff      = v_ge ? (v_q - est_q) : (est_q - v_q);

  // variance update: (1-G)*Pc >> 32 from the registered low product
  logic [DenW-1:0] var_sum;
  assign var_sum = DenW'(prod_q[ProdW-1:FracBits])
                 + (pc_q[FracBits]   ? DenW'(one_minus[FracBits-1:0])        : '0)
                 + (pc_q[FracBits+1] ? (DenW'(one_minus[FracBits-1:0]) << 1) : '0);

  // estimate update with round half up on the step
  logic [ProdW-1:0] rnd;
  logic [VoltW-1:0] step;
  logic [VoltW:0]   est_up;
  logic [VoltW-1:0] est_new;
  assign rnd     = prod_q + ProdW'(64'h8000_0000);
  assign step    = gain_q[FracBits] ? diff : rnd[FracBits+VoltW-1:FracBits];
  assign est_up  = (VoltW+1)'(est_q) + (VoltW+1)'(step);
  assign est_new = v_ge ? ((est_up > (VoltW+1)'(VoltFull)) ? VoltFull : est_up[VoltW-1:0])
                        : (est_q - step);

  // percent = est*20 >> 16, then band
  logic [VoltW+4:0] pct_prod;
  logic [PctW-1:0]  pct;
  band_e            band;
  assign pct_prod = ((VoltW+5)'(est_q) << 4) + ((VoltW+5)'(est_q) << 2);
  assign pct      = pct_prod[16+PctW-1:16];

  always_comb begin
    priority if (pct >= high_thr_q) begin
      band = BAND_HIGH;
    end else if (pct >= mid_thr_q) begin
      band = BAND_MID;
    end else begin
      band = BAND_LOW;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_GSET;
      ST_GSET:     state_d = (meas_noise_q == '0) ? ST_MUL_VAR : ST_GDIV;
      ST_GDIV:     if (cnt_q == '0) state_d = ST_MUL_VAR;
      ST_MUL_VAR:  state_d = ST_MUL_STEP;
      ST_MUL_STEP: state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_EMIT;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    pc_d        = pc_q;
    gain_d      = gain_q;
    vbase_d     = vbase_q;
    vrem_d      = vrem_q;
    v_d         = v_q;
    var_d       = var_q;
    est_d       = est_q;
    prod_d      = prod_q;
    out_volt_d  = out_volt_q;
    out_pct_d   = out_pct_q;
    out_band_d  = out_band_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = one_minus[FracBits-1:0];
    mul_b       = pc_q[FracBits-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          vbase_d = VoltW'(ScaleQ) * VoltW'(adc_sample_i);
          vrem_d  = ScaleW'(ScaleR) * ScaleW'(adc_sample_i) + ScaleW'(SampleFs / 2);
          pc_d    = PcW'(var_q) + PcW'(proc_noise_q);
        end
      end
      ST_GDIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          gain_d = {1'b0, quo_nx[FracBits-1:0]};
        end
      end
      ST_GSET: begin
        v_d = v_scaled;
        if (meas_noise_q == '0) begin
          gain_d = {1'b1, {FracBits{1'b0}}};
        end else begin
          rem_d = DenW'(pc_q);
          den_d = DenW'(pc_q) + DenW'(meas_noise_q);
          quo_d = '0;
          cnt_d = CntW'(FracBits - 1);
        end
      end
      ST_MUL_VAR: begin
        prod_d = mul_p;
      end
      ST_MUL_STEP: begin
        var_d  = one_minus[FracBits] ? pc_q[VarW-1:0] : var_sum[VarW-1:0];
        mul_a  = gain_q[FracBits-1:0];
        mul_b  = FracBits'(diff);
        prod_d = mul_p;
      end
      ST_UPDATE: begin
        est_d = est_new;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_volt_d  = est_q;
          out_pct_d   = pct;
          out_band_d  = band;
        end
      end
      default: ;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      var_q       <= {1'b1, {FracBits{1'b0}}};
      est_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      var_q       <= var_d;
      est_q       <= est_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    pc_q       <= pc_d;
    gain_q     <= gain_d;
    vbase_q    <= vbase_d;
    vrem_q     <= vrem_d;
    v_q        <= v_d;
    prod_q     <= prod_d;
    out_volt_q <= out_volt_d;
    out_pct_q  <= out_pct_d;
    out_band_q <= out_band_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign volt_estimate_o = out_volt_q;
  assign percent_o       = out_pct_q;
  assign band_o          = out_band_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again while busy");

  a_volt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> volt_estimate_o <= VoltFull)
    else $error("voltage estimate above full scale");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_o <= PctMax)
    else $error("percent above 100");

  a_band_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (percent_o >= high_thr_q) |-> band_o == BAND_HIGH)
    else $error("band disagrees with high threshold");

endmodule

`default_nettype wire
